[rtl/core/min_vruntime_task_scheduler_assert.svh]
// Assertion macros for the minimum run time task scheduler.
`ifndef MIN_VRUNTIME_TASK_SCHEDULER_ASSERT_SVH
`define MIN_VRUNTIME_TASK_SCHEDULER_ASSERT_SVH

// Flag any cycle in which the condition holds.
`define MVTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Require the consequent in the cycle after the antecedent.
`define MVTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/mvts_pkg.sv]
// Shared types, codes and the run time charge function of the task scheduler.
package mvts_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_WAITING  = 3'd0;
  localparam status_t ST_NOTIFIED = 3'd1;
  localparam status_t ST_PENDDEL  = 3'd2;
  localparam status_t ST_DEAD     = 3'd3;
  localparam status_t ST_READY    = 3'd4;
  localparam status_t ST_RUNNING  = 3'd5;
  localparam status_t ST_SLEEPING = 3'd6;

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_SCHED  = 3'd1;
  localparam logic [2:0] REQ_SLEEP  = 3'd2;
  localparam logic [2:0] REQ_NOTIFY = 3'd3;
  localparam logic [2:0] REQ_SETST  = 3'd4;

  localparam logic [47:0] RT_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_ADD, OP_SCHED, OP_SLEEP, OP_NOTIFY, OP_SETST, OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE, KIND_TASK, KIND_IDLE
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] now;
    logic [15:0] tid;
    logic [31:0] dur;
    logic [2:0]  nst;
    logic [63:0] ctx;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] ctx;
    logic [15:0] running_id;
    logic        idle;
    logic [15:0] assigned;
  } res_t;

  typedef struct packed {
    logic [15:0] id;
    status_t     status;
    logic [47:0] run_time;
    logic [31:0] deadline;
    logic [31:0] run_start;
    logic [63:0] ctx;
    logic        notify;
  } slot_rec_t;

  // Charge elapsed ticks with saturation and save the context word.
  function automatic slot_rec_t charge_rec(slot_rec_t r, logic [31:0] now,
                                           logic [63:0] ctx);
    logic [47:0] d;
    logic [47:0] room;
    slot_rec_t   o;
    d = {16'd0, now - r.run_start};
    room = RT_MAX - d;
    o = r;
    o.ctx = ctx;
    o.run_time = (r.run_time >= room) ? RT_MAX : r.run_time + d;
    return o;
  endfunction

endpackage

[rtl/core/mvts_front.sv]
// Command intake: decode the request code and queue commands for the engine.
module mvts_front import mvts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [31:0] now,
  input  logic [15:0] task_id,
  input  logic [31:0] duration,
  input  logic [2:0]  new_state,
  input  logic [63:0] context_in,
  output cmd_t        cmd,
  output logic        cmd_empty,
  input  logic        cmd_pop
);

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] n;
  logic       wr;
  logic       rd;
  op_t        op;

  // Classify the request code.
  always_comb begin
    unique case (req_type)
      REQ_ADD:    op = OP_ADD;
      REQ_SCHED:  op = OP_SCHED;
      REQ_SLEEP:  op = OP_SLEEP;
      REQ_NOTIFY: op = OP_NOTIFY;
      REQ_SETST:  op = OP_SETST;
      default:    op = OP_BAD;
    endcase
  end

  assign full      = (n == 2'd2);
  assign cmd_empty = (n == 2'd0);
  assign wr        = push && !full;
  assign rd        = cmd_pop && !cmd_empty;
  assign cmd       = q[rp];

  // Hold decoded words until the engine takes them.
  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= '{op: op, now: now, tid: task_id, dur: duration,
                 nst: new_state, ctx: context_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      n  <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      n <= n + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

[rtl/core/mvts_back.sv]
// Scheduling engine: task table memory and the sequencer that walks it.
module mvts_back import mvts_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  output res_t res,
  output logic res_push,
  input  logic res_full
);

  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_FIND_RD, S_FIND_CHK, S_FIND_DONE, S_NTF_SW,
    S_CMP_RD, S_CMP_CHK, S_CHARGE, S_MIN_RD, S_MIN_CHK, S_PICK, S_KILL, S_RESP
  } state_t;

  state_t      state;
  cmd_t        c;
  logic [CW-1:0] cnt;
  logic [15:0] next_id;
  kind_t       kind;
  kind_t       old_kind;
  logic [15:0] cur;
  logic [63:0] idle_ctx;
  logic [CW-1:0] i;
  logic [CW-1:0] w;
  logic [15:0] key;
  logic        second;
  logic        f_found;
  logic [IW-1:0] f_idx;
  slot_rec_t   f_rec;
  logic [IW-1:0] t_idx;
  slot_rec_t   t_rec;
  logic        c_found;
  logic [IW-1:0] c_idx;
  slot_rec_t   c_rec;
  logic        b_found;
  logic [IW-1:0] b_idx;
  slot_rec_t   b_rec;
  logic        r_ok;
  logic [63:0] r_ctx;
  logic [15:0] r_asg;

  slot_rec_t   mem [MAX_SLOTS];
  slot_rec_t   rd_rec;
  logic [IW-1:0] ra;
  logic        we;
  logic [IW-1:0] wa;
  slot_rec_t   wd;
  slot_rec_t   woke;
  slot_rec_t   new_rec;
  logic        chg_ok;
  logic        ntf_refuse;
  logic        elig;
  logic        better;

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_rec <= mem[ra];
  end

  assign ra = i[IW-1:0];

  always_comb begin
    woke = rd_rec;
    if (rd_rec.status == ST_SLEEPING && c.now >= rd_rec.deadline) woke.status = ST_READY;
    new_rec = '{id: next_id, status: ST_READY, run_time: 48'd0, deadline: 32'd0,
                run_start: 32'd0, ctx: c.ctx, notify: 1'b0};
    chg_ok = (old_kind == KIND_TASK) && c_found &&
             c_rec.status != ST_PENDDEL && c_rec.status != ST_DEAD;
    ntf_refuse = !f_found || (kind == KIND_TASK && cur == c.tid) ||
                 f_rec.status == ST_DEAD;
    elig = rd_rec.status == ST_READY || rd_rec.status == ST_RUNNING ||
           rd_rec.status == ST_NOTIFIED;
    better = !b_found || rd_rec.run_time < b_rec.run_time ||
             (rd_rec.run_time == b_rec.run_time && rd_rec.id < b_rec.id);
  end

  // Select the table write of the current step.
  always_comb begin
    we = 1'b0;
    wa = f_idx;
    wd = f_rec;
    unique case (state)
      S_START: begin
        if (c.op == OP_ADD && cnt < CNT_MAX) begin
          we = 1'b1;
          wa = cnt[IW-1:0];
          wd = new_rec;
        end
      end
      S_FIND_DONE: begin
        if (second) begin
          if (f_found && f_rec.status != ST_PENDDEL && f_rec.status != ST_DEAD) begin
            we = 1'b1;
            wd = charge_rec(f_rec, c.now, c.ctx);
          end
        end else if (f_found) begin
          priority case (c.op)
            OP_SLEEP: begin
              we = 1'b1;
              wd.deadline = c.now + c.dur;
              wd.status = ST_SLEEPING;
            end
            OP_SETST: begin
              we = (c.nst <= ST_READY);
              wd.status = c.nst;
            end
            OP_NOTIFY: begin
              we = !ntf_refuse && f_rec.status != ST_WAITING;
              wd.notify = 1'b1;
            end
            default: we = 1'b0;
          endcase
        end
      end
      S_NTF_SW: begin
        we = 1'b1;
        wa = t_idx;
        wd = t_rec;
        wd.status = ST_RUNNING;
        wd.run_start = c.now;
      end
      S_CMP_CHK: begin
        we = (rd_rec.status != ST_DEAD);
        wa = w[IW-1:0];
        wd = woke;
      end
      S_CHARGE: begin
        we = chg_ok;
        wa = c_idx;
        wd = charge_rec(c_rec, c.now, c.ctx);
      end
      S_PICK: begin
        we = b_found;
        wa = b_idx;
        wd = b_rec;
        wd.status = ST_RUNNING;
        wd.run_start = c.now;
      end
      S_KILL: begin
        we = (old_kind == KIND_TASK) && c_found && c_rec.status == ST_PENDDEL;
        wa = c_idx;
        wd = c_rec;
        wd.status = ST_DEAD;
      end
      default: we = 1'b0;
    endcase
  end

  assign cmd_pop  = (state == S_IDLE) && !cmd_empty;
  assign res_push = (state == S_RESP) && !res_full;
  assign res = '{ok: r_ok, ctx: r_ctx,
                 running_id: (kind == KIND_TASK) ? cur : 16'd0,
                 idle: (kind == KIND_IDLE), assigned: r_asg};

  // Sequence each command over the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      next_id  <= 16'd1;
      kind     <= KIND_NONE;
      cur      <= 16'd0;
      idle_ctx <= 64'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            c     <= cmd;
            r_ok  <= 1'b0;
            r_ctx <= cmd.ctx;
            r_asg <= 16'd0;
            state <= S_START;
          end
        end
        S_START: begin
          i      <= '0;
          w      <= '0;
          second <= 1'b0;
          priority case (c.op)
            OP_ADD: begin
              if (cnt < CNT_MAX) begin
                r_ok    <= 1'b1;
                r_asg   <= next_id;
                next_id <= next_id + 16'd1;
                cnt     <= cnt + 1'b1;
              end
              state <= S_RESP;
            end
            OP_SCHED: begin
              c_found  <= 1'b0;
              b_found  <= 1'b0;
              old_kind <= kind;
              state    <= S_CMP_RD;
            end
            OP_SLEEP: begin
              key   <= cur;
              state <= (kind == KIND_TASK) ? S_FIND_RD : S_RESP;
            end
            OP_NOTIFY, OP_SETST: begin
              key   <= c.tid;
              state <= S_FIND_RD;
            end
            default: state <= S_RESP;
          endcase
        end
        S_FIND_RD: begin
          if (i == cnt) begin
            f_found <= 1'b0;
            state   <= S_FIND_DONE;
          end else begin
            state <= S_FIND_CHK;
          end
        end
        S_FIND_CHK: begin
          if (rd_rec.id == key) begin
            f_found <= 1'b1;
            f_idx   <= i[IW-1:0];
            f_rec   <= rd_rec;
            state   <= S_FIND_DONE;
          end else begin
            i     <= i + 1'b1;
            state <= S_FIND_RD;
          end
        end
        S_FIND_DONE: begin
          state <= S_RESP;
          if (second) begin
            state <= S_NTF_SW;
          end else if (f_found) begin
            priority case (c.op)
              OP_SLEEP: r_ok <= 1'b1;
              OP_SETST: r_ok <= (c.nst <= ST_READY);
              OP_NOTIFY: begin
                if (!ntf_refuse) begin
                  r_ok <= 1'b1;
                  if (f_rec.status == ST_WAITING) begin
                    t_idx <= f_idx;
                    t_rec <= f_rec;
                    if (kind == KIND_TASK) begin
                      second <= 1'b1;
                      key    <= cur;
                      i      <= '0;
                      state  <= S_FIND_RD;
                    end else begin
                      if (kind == KIND_IDLE) idle_ctx <= c.ctx;
                      state <= S_NTF_SW;
                    end
                  end
                end
              end
              default: r_ok <= 1'b0;
            endcase
          end
        end
        S_NTF_SW: begin
          kind  <= KIND_TASK;
          cur   <= c.tid;
          r_ctx <= t_rec.ctx;
          state <= S_RESP;
        end
        S_CMP_RD: begin
          if (i == cnt) begin
            cnt   <= w;
            state <= S_CHARGE;
          end else begin
            state <= S_CMP_CHK;
          end
        end
        S_CMP_CHK: begin
          if (rd_rec.status != ST_DEAD) begin
            if (old_kind == KIND_TASK && !c_found && rd_rec.id == cur) begin
              c_found <= 1'b1;
              c_idx   <= w[IW-1:0];
              c_rec   <= woke;
            end
            w <= w + 1'b1;
          end
          i     <= i + 1'b1;
          state <= S_CMP_RD;
        end
        S_CHARGE: begin
          if (old_kind == KIND_IDLE) idle_ctx <= c.ctx;
          i     <= '0;
          state <= S_MIN_RD;
        end
        S_MIN_RD: begin
          state <= (i == cnt) ? S_PICK : S_MIN_CHK;
        end
        S_MIN_CHK: begin
          if (elig && better) begin
            b_found <= 1'b1;
            b_idx   <= i[IW-1:0];
            b_rec   <= rd_rec;
          end
          i     <= i + 1'b1;
          state <= S_MIN_RD;
        end
        S_PICK: begin
          if (b_found) begin
            kind  <= KIND_TASK;
            cur   <= b_rec.id;
            r_ctx <= b_rec.ctx;
          end else begin
            kind  <= KIND_IDLE;
            cur   <= 16'd0;
            r_ctx <= idle_ctx;
          end
          state <= S_KILL;
        end
        S_KILL: begin
          r_ok  <= 1'b1;
          state <= S_RESP;
        end
        S_RESP: begin
          if (!res_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/mvts_outq.sv]
// Result queue between the engine and the consumer.
module mvts_outq import mvts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  res_t        res,
  input  logic        res_push,
  output logic        res_full,
  output logic        empty,
  input  logic        pop,
  output logic        ok,
  output logic [63:0] context_out,
  output logic [15:0] running_id,
  output logic        idle_running,
  output logic [15:0] assigned_id
);

  res_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] n;
  logic       wr;
  logic       rd;

  assign res_full     = (n == 2'd2);
  assign empty        = (n == 2'd0);
  assign wr           = res_push && !res_full;
  assign rd           = pop && !empty;
  assign ok           = q[rp].ok;
  assign context_out  = q[rp].ctx;
  assign running_id   = q[rp].running_id;
  assign idle_running = q[rp].idle;
  assign assigned_id  = q[rp].assigned;

  // Store result words in arrival order.
  always_ff @(posedge clk) begin
    if (wr) q[wp] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      n  <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      n <= n + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

[rtl/core/min_vruntime_task_scheduler.sv]
// Top level of the minimum run time task scheduler.
//
//  channel  handshake        word
//  command  push / full      req_type, now, task_id, duration, new_state, context_in
//  result   empty / pop      ok, context_out, running_id, idle_running, assigned_id
//
// Commands run one at a time through a table walk with one memory read port;
// each slot visited takes a read step and a check step. Lookups scan until the id
// matches; schedule makes a compaction pass and then a minimum run time pass.
// Two command words and two result words are buffered, so either side may stall.
// Reset (synchronous) empties the queues and the table; no clearing pass runs.
module min_vruntime_task_scheduler import mvts_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [31:0] now,
  input  logic [15:0] task_id,
  input  logic [31:0] duration,
  input  logic [2:0]  new_state,
  input  logic [63:0] context_in,
  output logic        empty,
  input  logic        pop,
  output logic        ok,
  output logic [63:0] context_out,
  output logic [15:0] running_id,
  output logic        idle_running,
  output logic [15:0] assigned_id
);

  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;
  res_t res;
  logic res_push;
  logic res_full;

  mvts_front u_front (
    .clk, .rst, .push, .full, .req_type, .now, .task_id, .duration,
    .new_state, .context_in, .cmd, .cmd_empty, .cmd_pop
  );

  mvts_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk, .rst, .cmd, .cmd_empty, .cmd_pop, .res, .res_push, .res_full
  );

  mvts_outq u_outq (
    .clk, .rst, .res, .res_push, .res_full, .empty, .pop, .ok, .context_out,
    .running_id, .idle_running, .assigned_id
  );

`include "min_vruntime_task_scheduler_assert.svh"

  `MVTS_ASSERT_NEVER(a_no_push_full, res_push && res_full, "result pushed into full queue")
  `MVTS_ASSERT_NEVER(a_no_pop_empty, cmd_pop && cmd_empty, "command taken from empty queue")
  `MVTS_ASSERT_NEVER(a_idle_no_id, !empty && idle_running && running_id != 16'd0, "idle with task id")
  `MVTS_ASSERT_NEXT(a_push_fills, res_push && !pop, !empty, "result word lost")

endmodule

[verif/min_vruntime_task_scheduler_tb.sv]
// Self-checking testbench for the minimum run time task scheduler.
module min_vruntime_task_scheduler_tb import mvts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [2:0]  req;
    logic [31:0] now;
    logic [15:0] tid;
    logic [31:0] dur;
    logic [2:0]  nst;
    logic [63:0] ctx;
  } sched_cmd_t;

  typedef struct {
    logic        ok;
    logic [63:0] ctx;
    logic [15:0] rid;
    logic        idle;
    logic [15:0] asg;
  } sched_res_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [2:0]  req_type;
  logic [31:0] now;
  logic [15:0] task_id;
  logic [31:0] duration;
  logic [2:0]  new_state;
  logic [63:0] context_in;
  logic        empty;
  logic        pop;
  logic        ok;
  logic [63:0] context_out;
  logic [15:0] running_id;
  logic        idle_running;
  logic [15:0] assigned_id;

  sched_cmd_t cmd_q[$];
  sched_res_t want_q[$];
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_left;
  int         errors;
  int         cycles;
  int         accepted;
  int         checked;
  int         switches;

  // Shadow of the task table.
  logic [15:0] sh_id[SLOTS];
  logic [2:0]  sh_st[SLOTS];
  logic [47:0] sh_rt[SLOTS];
  logic [31:0] sh_dl[SLOTS];
  logic [31:0] sh_rs[SLOTS];
  logic [63:0] sh_ctx[SLOTS];
  logic        sh_nf[SLOTS];
  int          sh_cnt;
  logic [15:0] sh_next_id;
  kind_t       sh_kind;
  logic [15:0] sh_cur;
  logic [63:0] sh_idle_ctx;

  // Stimulus generation state.
  logic [31:0] gen_tick;
  logic [15:0] gen_next_id;

  min_vruntime_task_scheduler #(.MAX_SLOTS(SLOTS)) DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int lookup(logic [15:0] id);
    for (int i = 0; i < sh_cnt; i++)
      if (sh_id[i] == id) return i;
    return -1;
  endfunction

  // Charge elapsed ticks to the current task, or save the idle context.
  function automatic void charge_running(logic [31:0] t, logic [63:0] c);
    int s;
    logic [47:0] d;
    if (sh_kind == KIND_IDLE) begin
      sh_idle_ctx = c;
    end else if (sh_kind == KIND_TASK) begin
      s = lookup(sh_cur);
      if (s >= 0 && sh_st[s] != ST_PENDDEL && sh_st[s] != ST_DEAD) begin
        d = {16'd0, t - sh_rs[s]};
        sh_ctx[s] = c;
        sh_rt[s] = (sh_rt[s] >= RT_MAX - d) ? RT_MAX : sh_rt[s] + d;
      end
    end
  endfunction

  // Apply one command word to the shadow table and queue the expected word.
  function automatic void predict_sched(sched_cmd_t c);
    sched_res_t r;
    int s, w, best;
    kind_t old_kind;
    logic [15:0] old_id;
    r.ok = 1'b0;
    r.ctx = c.ctx;
    r.asg = '0;
    case (c.req)
      REQ_ADD: begin
        if (sh_cnt < SLOTS) begin
          sh_id[sh_cnt] = sh_next_id;
          sh_st[sh_cnt] = ST_READY;
          sh_rt[sh_cnt] = '0;
          sh_dl[sh_cnt] = '0;
          sh_rs[sh_cnt] = '0;
          sh_ctx[sh_cnt] = c.ctx;
          sh_nf[sh_cnt] = 1'b0;
          r.asg = sh_next_id;
          sh_next_id++;
          sh_cnt++;
          r.ok = 1'b1;
        end
      end
      REQ_SCHED: begin
        old_kind = sh_kind;
        old_id = sh_cur;
        w = 0;
        // drop dead tasks and pack the table
        for (int i = 0; i < sh_cnt; i++) begin
          if (sh_st[i] != ST_DEAD) begin
            sh_id[w] = sh_id[i]; sh_st[w] = sh_st[i]; sh_rt[w] = sh_rt[i];
            sh_dl[w] = sh_dl[i]; sh_rs[w] = sh_rs[i]; sh_ctx[w] = sh_ctx[i];
            sh_nf[w] = sh_nf[i];
            w++;
          end
        end
        sh_cnt = w;
        for (int i = 0; i < sh_cnt; i++)
          if (sh_st[i] == ST_SLEEPING && c.now >= sh_dl[i]) sh_st[i] = ST_READY;
        charge_running(c.now, c.ctx);
        best = -1;
        for (int i = 0; i < sh_cnt; i++) begin
          if (sh_st[i] == ST_READY || sh_st[i] == ST_RUNNING || sh_st[i] == ST_NOTIFIED)
            if (best < 0 || sh_rt[i] < sh_rt[best] ||
                (sh_rt[i] == sh_rt[best] && sh_id[i] < sh_id[best]))
              best = i;
        end
        if (best >= 0) begin
          sh_st[best] = ST_RUNNING;
          sh_rs[best] = c.now;
          sh_kind = KIND_TASK;
          sh_cur = sh_id[best];
          r.ctx = sh_ctx[best];
        end else begin
          sh_kind = KIND_IDLE;
          sh_cur = '0;
          r.ctx = sh_idle_ctx;
        end
        if (old_kind == KIND_TASK) begin
          s = lookup(old_id);
          if (s >= 0 && sh_st[s] == ST_PENDDEL) sh_st[s] = ST_DEAD;
        end
        r.ok = 1'b1;
      end
      REQ_SLEEP: begin
        if (sh_kind == KIND_TASK) begin
          s = lookup(sh_cur);
          if (s >= 0) begin
            sh_dl[s] = c.now + c.dur;
            sh_st[s] = ST_SLEEPING;
            r.ok = 1'b1;
          end
        end
      end
      REQ_NOTIFY: begin
        s = lookup(c.tid);
        if (s >= 0 && !(sh_kind == KIND_TASK && sh_cur == c.tid) && sh_st[s] != ST_DEAD) begin
          r.ok = 1'b1;
          if (sh_st[s] == ST_WAITING) begin
            charge_running(c.now, c.ctx);
            sh_st[s] = ST_RUNNING;
            sh_rs[s] = c.now;
            sh_kind = KIND_TASK;
            sh_cur = c.tid;
            r.ctx = sh_ctx[s];
            switches++;
          end else begin
            sh_nf[s] = 1'b1;
          end
        end
      end
      REQ_SETST: begin
        s = lookup(c.tid);
        if (s >= 0 && c.nst <= ST_READY) begin
          sh_st[s] = c.nst;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.rid = (sh_kind == KIND_TASK) ? sh_cur : 16'd0;
    r.idle = (sh_kind == KIND_IDLE);
    want_q.push_back(r);
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] exp);
    $display("MISMATCH word %0d %s: got %h expected %h", checked, field, got, exp);
    errors++;
  endtask

  // Accept command words and predict their results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && push && !full) begin
      predict_sched(cmd_q.pop_front());
      accepted++;
    end
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin
    sched_res_t e;
    if (!rst && pop && !empty) begin
      if (want_q.size() == 0) begin
        report("unexpected word", {63'd0, ok}, 64'd0);
      end else begin
        e = want_q.pop_front();
        if (ok !== e.ok) report("ok", ok, e.ok);
        if (context_out !== e.ctx) report("context_out", context_out, e.ctx);
        if (running_id !== e.rid) report("running_id", running_id, e.rid);
        if (idle_running !== e.idle) report("idle_running", idle_running, e.idle);
        if (assigned_id !== e.asg) report("assigned_id", assigned_id, e.asg);
      end
      checked++;
    end
  end

  // Count down a long receiver hold.
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Drive the command side.
  always @(negedge clk) begin
    if (!rst && cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      push <= 1'b1;
      req_type <= cmd_q[0].req;
      now <= cmd_q[0].now;
      task_id <= cmd_q[0].tid;
      duration <= cmd_q[0].dur;
      new_state <= cmd_q[0].nst;
      context_in <= cmd_q[0].ctx;
    end else begin
      push <= 1'b0;
    end
  end

  // Drive the result side.
  always @(negedge clk) begin
    pop <= !rst && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  // Stop on a hung run.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("min_vruntime_task_scheduler_tb: done, errors");
      $finish;
    end
  end

  function automatic void add_cmd(logic [2:0] rq, logic [31:0] t, logic [15:0] id,
                                  logic [31:0] d, logic [2:0] ns, logic [63:0] c);
    sched_cmd_t k;
    k.req = rq; k.now = t; k.tid = id; k.dur = d; k.nst = ns; k.ctx = c;
    cmd_q.push_back(k);
  endfunction

  // Build one random command, mostly aimed at ids that are likely live.
  function automatic void add_random_cmd();
    int pick;
    logic [15:0] id;
    logic [31:0] d;
    logic [2:0] rq;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) gen_tick = $urandom;
    else gen_tick = gen_tick + $urandom_range(2000);
    if ($urandom_range(9) == 0) id = 16'($urandom);
    else id = gen_next_id - 16'($urandom_range(12)) - 16'd1;
    d = ($urandom_range(7) == 0) ? $urandom : $urandom_range(5000);
    if (pick < 16) begin
      rq = REQ_ADD;
      gen_next_id++;
    end else if (pick < 48) rq = REQ_SCHED;
    else if (pick < 58) rq = REQ_SLEEP;
    else if (pick < 74) rq = REQ_NOTIFY;
    else rq = REQ_SETST;
    add_cmd(rq, gen_tick, id, d, 3'($urandom_range(ST_READY)), {$urandom, $urandom});
  endfunction

  task automatic wait_drained();
    wait (cmd_q.size() == 0 && want_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int n, int sidle, int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) add_random_cmd();
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    req_type = REQ_ADD;
    now = '0;
    task_id = '0;
    duration = '0;
    new_state = ST_WAITING;
    context_in = '0;
    errors = 0;
    cycles = 0;
    accepted = 0;
    checked = 0;
    switches = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sh_cnt = 0;
    sh_next_id = 16'd1;
    sh_kind = KIND_NONE;
    sh_cur = '0;
    sh_idle_ctx = '0;
    gen_tick = 32'd100;
    gen_next_id = 16'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle fallback, refused sleep, switch by notify, refusals, full table.
    add_cmd(REQ_SCHED, 32'd0, '0, '0, ST_WAITING, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cmd(REQ_SLEEP, 32'd5, '0, 32'd10, ST_WAITING, 64'd1);
    add_cmd(REQ_ADD, 32'd6, '0, '0, ST_WAITING, 64'd0);
    add_cmd(REQ_ADD, 32'd7, '0, '0, ST_WAITING, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cmd(REQ_ADD, 32'd8, '0, '0, ST_WAITING, 64'h1234_5678_9ABC_DEF0);
    add_cmd(REQ_SCHED, 32'd10, '0, '0, ST_WAITING, 64'hA5A5);
    add_cmd(REQ_SLEEP, 32'd20, '0, 32'hFFFF_FFFF, ST_WAITING, 64'hB);
    add_cmd(REQ_NOTIFY, 32'd21, 16'hFFFF, '0, ST_WAITING, 64'hC);
    add_cmd(REQ_SETST, 32'd22, 16'd2, '0, ST_WAITING, 64'hD);
    add_cmd(REQ_NOTIFY, 32'd30, 16'd2, '0, ST_WAITING, 64'hE);
    add_cmd(REQ_NOTIFY, 32'd31, 16'd2, '0, ST_WAITING, 64'hF);
    add_cmd(REQ_SETST, 32'd32, 16'd3, '0, ST_DEAD, 64'h10);
    add_cmd(REQ_NOTIFY, 32'd33, 16'd3, '0, ST_WAITING, 64'h11);
    add_cmd(REQ_NOTIFY, 32'd34, 16'd1, '0, ST_WAITING, 64'h12);
    add_cmd(REQ_SETST, 32'd35, 16'd2, '0, ST_PENDDEL, 64'h13);
    add_cmd(REQ_SETST, 32'd36, 16'd1, '0, ST_NOTIFIED, 64'h14);
    add_cmd(REQ_SCHED, 32'hFFFF_FFFF, '0, '0, ST_WAITING, 64'h15);
    add_cmd(REQ_SCHED, 32'h0000_0040, '0, '0, ST_WAITING, 64'h16);
    for (int i = 0; i < 16; i++)
      add_cmd(REQ_ADD, 32'd50, '0, '0, ST_WAITING, {$urandom, $urandom});
    add_cmd(REQ_SETST, 32'd60, 16'd4, '0, ST_READY, 64'h17);
    gen_next_id = 16'd19;
    wait_drained();

    // Random phases with varied idling on each side.
    run_phase(160, 0, 0);
    run_phase(100, 86, 0);
    run_phase(100, 0, 86);
    run_phase(100, 27, 27);

    // Hold off the receiver so the block backs up and stalls its input.
    hold_left = 400;
    run_phase(120, 0, 0);
    run_phase(70, 10, 40);

    $display("covered %0d command words, %0d results checked, %0d notify switches",
             accepted, checked, switches);
    $display("phases: no idling, sender idle, receiver stall, both, long receiver hold");
    if (errors == 0) begin
      $display("min_vruntime_task_scheduler_tb: done, clean");
    end else begin
      $display("min_vruntime_task_scheduler_tb: done, errors");
    end
    $finish;
  end

endmodule
